@@ src/tpfc_pkg.sv @@
package tpfc_pkg;

    // Field widths
    localparam int SAMPLE_W    = 10;
    localparam int TEMP_W      = 18;
    localparam int GAIN_W      = 16;
    localparam int DUTY_W      = 8;
    localparam int LEVEL_W     = 2;
    localparam int LOWEST_W    = 17;
    localparam int INTEG_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    // Datapath widths
    localparam int ERR_W      = TEMP_W + 1;
    localparam int MUL_A_W    = GAIN_W + 1;
    localparam int MUL_B_W    = 21;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int DIVIDEND_W = 21;
    localparam int QUOT_W     = 17;

    // Conversion and controller constants
    localparam logic signed [MUL_A_W-1:0] TEMP_STEP   = 17'sd125;
    localparam logic signed [TEMP_W-1:0]  TEMP_OFFSET = 18'sd12800;
    localparam logic [INTEG_W-1:0]        INTEG_MAX   = 16'd65280;
    localparam logic [DUTY_W-1:0]         DUTY_MAX    = 8'd255;
    localparam logic signed [PROD_W-1:0]  DUTY_LIMIT  = 38'sd16711680;

    // Reset values
    localparam logic signed [TEMP_W-1:0] MAX_RECORD_RST  = -18'sd25600;
    localparam logic signed [TEMP_W-1:0] MIN_RECORD_RST  = 18'sd38400;
    localparam logic signed [TEMP_W-1:0] SETPOINT_RST    = 18'sd7168;
    localparam logic [GAIN_W-1:0]        PROP_GAIN_RST   = 16'd5120;
    localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST  = 16'd512;
    localparam logic signed [TEMP_W-1:0] UPPER_LIMIT_RST = 18'sd8960;
    localparam logic signed [TEMP_W-1:0] LOWER_LIMIT_RST = 18'sd5120;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SETPOINT    = 3'd0,
        REG_PROP_GAIN   = 3'd1,
        REG_INTEG_GAIN  = 3'd2,
        REG_UPPER_LIMIT = 3'd3,
        REG_LOWER_LIMIT = 3'd4
    } cfg_reg_t;

    typedef enum logic [LEVEL_W-1:0] {
        LEVEL_OK   = 2'd0,
        LEVEL_COLD = 2'd1,
        LEVEL_CRIT = 2'd2
    } level_t;

endpackage

@@ src/tpfc_sample_if.sv @@
interface tpfc_sample_if;
    logic                          valid;
    logic                          ready;
    logic [tpfc_pkg::SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

@@ src/tpfc_result_if.sv @@
interface tpfc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [tpfc_pkg::TEMP_W-1:0]   temperature;
    logic [tpfc_pkg::DUTY_W-1:0]          fan_duty;
    logic [tpfc_pkg::LEVEL_W-1:0]         alert_level;
    logic                                buzzer_start;
    logic signed [tpfc_pkg::TEMP_W-1:0]   highest_seen;
    logic signed [tpfc_pkg::LOWEST_W-1:0] lowest_seen;
    logic                                record_changed;

    modport source (
        output valid, output temperature, output fan_duty, output alert_level,
        output buzzer_start, output highest_seen, output lowest_seen,
        output record_changed, input ready
    );
    modport sink (
        input valid, input temperature, input fan_duty, input alert_level,
        input buzzer_start, input highest_seen, input lowest_seen,
        input record_changed, output ready
    );
endinterface

@@ src/temperature_pi_fan_controller.sv @@
// A sample transfer passes through the window update, the scaling multiply,
// the 21-step restoring divider (average = sum*125/count) and the PI states
// before its result is valid. A new sample is taken only once the sequencer
// is idle, even while the last result still waits for a transfer.
// Reset (rst_n, async, active low): window empty, integrator zero, records at
// -100/150 degC, level ok, registers at their default values, no result.
module temperature_pi_fan_controller #(
    parameter int AVG_DEPTH = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    tpfc_sample_if.sink                         samples,
    tpfc_result_if.source                       results,
    input  logic                                cfg_wr_en,
    input  logic [tpfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tpfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Window sizing follows from the averaging depth
    localparam int IDX_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int FILL_W = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W  = $clog2(1023 * AVG_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,     // ring write, running sum, fill count
        S_SCALE,      // sum * 125 on the shared multiplier
        S_DIV_START,
        S_DIV_WAIT,   // divide by fill count, then remove the offset
        S_RECORD,     // extremes, error, alert level
        S_MUL_P,      // prop_gain * err
        S_MUL_I,      // integ_gain * err
        S_WINDUP,     // anti-windup test and tentative integrator
        S_INTEG,      // clamp and commit integrator
        S_DUTY,       // final PI sum and duty clamp
        S_FINISH      // hand result to output register
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic signed [tpfc_pkg::TEMP_W-1:0] setpoint_reg;
    logic [tpfc_pkg::GAIN_W-1:0]        prop_gain_reg;
    logic [tpfc_pkg::GAIN_W-1:0]        integ_gain_reg;
    logic signed [tpfc_pkg::TEMP_W-1:0] upper_limit_reg;
    logic signed [tpfc_pkg::TEMP_W-1:0] lower_limit_reg;

    // Block state
    logic [tpfc_pkg::SAMPLE_W-1:0]      ring_mem [AVG_DEPTH];
    logic [IDX_W-1:0]                   idx_reg;
    logic [FILL_W-1:0]                  fill_reg;
    logic [SUM_W-1:0]                   sum_reg;
    logic [SUM_W-1:0]                   sum_next;
    logic [tpfc_pkg::INTEG_W-1:0]       integ_reg;
    logic signed [tpfc_pkg::TEMP_W-1:0] max_reg;
    logic signed [tpfc_pkg::TEMP_W-1:0] min_reg;
    tpfc_pkg::level_t                   prev_level_reg;

    // Working registers
    logic [tpfc_pkg::SAMPLE_W-1:0]      sample_reg;
    logic signed [tpfc_pkg::TEMP_W-1:0] temp_reg;
    logic signed [tpfc_pkg::ERR_W-1:0]  err_reg;
    logic signed [tpfc_pkg::PROD_W-1:0] mul_reg;
    logic signed [tpfc_pkg::PROD_W-1:0] prop_reg;
    logic signed [tpfc_pkg::PROD_W-1:0] integ_sum_reg;
    logic                               win_reg;
    logic [tpfc_pkg::DUTY_W-1:0]        duty_reg;
    tpfc_pkg::level_t                   level_reg;
    logic                               buz_reg;
    logic                               rec_reg;

    // Output register
    logic                                 out_valid_reg;
    logic signed [tpfc_pkg::TEMP_W-1:0]   out_temp_reg;
    logic [tpfc_pkg::DUTY_W-1:0]          out_duty_reg;
    tpfc_pkg::level_t                     out_level_reg;
    logic                                 out_buz_reg;
    logic signed [tpfc_pkg::TEMP_W-1:0]   out_high_reg;
    logic signed [tpfc_pkg::LOWEST_W-1:0] out_low_reg;
    logic                                 out_rec_reg;

    // Shared multiplier
    logic signed [tpfc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [tpfc_pkg::MUL_B_W-1:0] mul_b;
    logic                                mul_en;

    // Shared PI adder: prop term plus integrator in 1/65536 duty
    logic signed [tpfc_pkg::PROD_W-1:0] integ_scaled;
    logic signed [tpfc_pkg::PROD_W-1:0] pi_sum;

    // Divider
    logic                              div_start;
    logic                              div_done;
    logic [tpfc_pkg::DIVIDEND_W-1:0]   div_quot;
    logic signed [tpfc_pkg::TEMP_W-1:0] temp_calc;

    tpfc_pkg::level_t level_calc;
    logic             sample_xfer;
    logic             out_load;
    logic [tpfc_pkg::INTEG_W-1:0] integ_clamped;
    logic [tpfc_pkg::DUTY_W-1:0]  duty_calc;

    assign sample_xfer   = samples.valid && samples.ready;
    assign samples.ready = (state_reg == S_IDLE);
    assign out_load      = (state_reg == S_FINISH) && (!out_valid_reg || results.ready);
    assign div_start     = (state_reg == S_DIV_START);

    // Operand select for the one multiplier
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = tpfc_pkg::TEMP_STEP;
        mul_b  = signed'(tpfc_pkg::MUL_B_W'(sum_reg));
        unique case (state_reg)
            S_SCALE:
            begin
                mul_a = tpfc_pkg::TEMP_STEP;
                mul_b = signed'(tpfc_pkg::MUL_B_W'(sum_reg));
            end
            S_MUL_P:
            begin
                mul_a = signed'({1'b0, prop_gain_reg});
                mul_b = tpfc_pkg::MUL_B_W'(err_reg);
            end
            S_MUL_I:
            begin
                mul_a = signed'({1'b0, integ_gain_reg});
                mul_b = tpfc_pkg::MUL_B_W'(err_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Window update: grow while filling, then replace the oldest sample
    always_comb
    begin
        if (fill_reg < FILL_W'(AVG_DEPTH))
        begin
            sum_next = SUM_W'((SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(sample_reg));
        end
        else
        begin
            sum_next = SUM_W'((SUM_W + 1)'(sum_reg) - (SUM_W + 1)'(ring_mem[idx_reg])
                              + (SUM_W + 1)'(sample_reg));
        end
    end

    tpfc_divider #(
        .DIVIDEND_W (tpfc_pkg::DIVIDEND_W),
        .DIVISOR_W  (FILL_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_reg[tpfc_pkg::DIVIDEND_W-1:0]),
        .divisor  (fill_reg),
        .quotient (div_quot),
        .done     (div_done)
    );

    // Quotient never exceeds 1023*125, so 17 bits hold it
    assign temp_calc = signed'({1'b0, div_quot[tpfc_pkg::QUOT_W-1:0]})
                       - tpfc_pkg::TEMP_OFFSET;

    // Critical wins when the limits cross
    always_comb
    begin
        priority if (temp_reg >= upper_limit_reg)
        begin
            level_calc = tpfc_pkg::LEVEL_CRIT;
        end
        else if (temp_reg <= lower_limit_reg)
        begin
            level_calc = tpfc_pkg::LEVEL_COLD;
        end
        else
        begin
            level_calc = tpfc_pkg::LEVEL_OK;
        end
    end

    assign integ_scaled = signed'(tpfc_pkg::PROD_W'({integ_reg, 8'h00}));
    assign pi_sum       = prop_reg + integ_scaled;

    always_comb
    begin
        priority if (integ_sum_reg < 0)
        begin
            integ_clamped = '0;
        end
        else if (integ_sum_reg > signed'(tpfc_pkg::PROD_W'(tpfc_pkg::INTEG_MAX)))
        begin
            integ_clamped = tpfc_pkg::INTEG_MAX;
        end
        else
        begin
            integ_clamped = integ_sum_reg[tpfc_pkg::INTEG_W-1:0];
        end
    end

    always_comb
    begin
        priority if (pi_sum < 0)
        begin
            duty_calc = '0;
        end
        else if (pi_sum >= tpfc_pkg::DUTY_LIMIT)
        begin
            duty_calc = tpfc_pkg::DUTY_MAX;
        end
        else
        begin
            duty_calc = pi_sum[23:16];
        end
    end

    // Sequencer, control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            fill_reg        <= '0;
            sum_reg         <= '0;
            integ_reg       <= '0;
            max_reg         <= tpfc_pkg::MAX_RECORD_RST;
            min_reg         <= tpfc_pkg::MIN_RECORD_RST;
            prev_level_reg  <= tpfc_pkg::LEVEL_OK;
            win_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            setpoint_reg    <= tpfc_pkg::SETPOINT_RST;
            prop_gain_reg   <= tpfc_pkg::PROP_GAIN_RST;
            integ_gain_reg  <= tpfc_pkg::INTEG_GAIN_RST;
            upper_limit_reg <= tpfc_pkg::UPPER_LIMIT_RST;
            lower_limit_reg <= tpfc_pkg::LOWER_LIMIT_RST;
        end
        else
        begin
            // Result handoff
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Register writes are to arrive only while idle; the block does not enforce it
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    tpfc_pkg::REG_SETPOINT:
                    begin
                        setpoint_reg <= signed'(cfg_data);
                    end
                    tpfc_pkg::REG_PROP_GAIN:
                    begin
                        prop_gain_reg <= cfg_data[tpfc_pkg::GAIN_W-1:0];
                    end
                    tpfc_pkg::REG_INTEG_GAIN:
                    begin
                        integ_gain_reg <= cfg_data[tpfc_pkg::GAIN_W-1:0];
                    end
                    tpfc_pkg::REG_UPPER_LIMIT:
                    begin
                        upper_limit_reg <= signed'(cfg_data);
                    end
                    tpfc_pkg::REG_LOWER_LIMIT:
                    begin
                        lower_limit_reg <= signed'(cfg_data);
                    end
                    default:
                    begin
                    end
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_wr_en && (cfg_index == tpfc_pkg::REG_SETPOINT))
                    begin
                        integ_reg <= '0;
                    end
                    if (sample_xfer)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    sum_reg <= sum_next;
                    if (fill_reg < FILL_W'(AVG_DEPTH))
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    if (idx_reg == IDX_W'(AVG_DEPTH - 1))
                    begin
                        idx_reg <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    state_reg <= S_DIV_START;
                end
                S_DIV_START:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_RECORD;
                    end
                end
                S_RECORD:
                begin
                    if (temp_reg > max_reg)
                    begin
                        max_reg <= temp_reg;
                    end
                    if (temp_reg < min_reg)
                    begin
                        min_reg <= temp_reg;
                    end
                    prev_level_reg <= level_calc;
                    state_reg      <= S_MUL_P;
                end
                S_MUL_P:
                begin
                    state_reg <= S_MUL_I;
                end
                S_MUL_I:
                begin
                    state_reg <= S_WINDUP;
                end
                S_WINDUP:
                begin
                    // Integrate only while the unclamped output is inside its range
                    win_reg   <= (pi_sum > 0) && (pi_sum < tpfc_pkg::DUTY_LIMIT);
                    state_reg <= S_INTEG;
                end
                S_INTEG:
                begin
                    if (win_reg)
                    begin
                        integ_reg <= integ_clamped;
                    end
                    state_reg <= S_DUTY;
                end
                S_DUTY:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath payload, ring storage and output payload
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            sample_reg <= samples.adc_sample;
        end
        if (state_reg == S_UPDATE)
        begin
            ring_mem[idx_reg] <= sample_reg;
        end
        if (mul_en)
        begin
            mul_reg <= mul_a * mul_b;
        end
        if ((state_reg == S_DIV_WAIT) && div_done)
        begin
            temp_reg <= temp_calc;
        end
        if (state_reg == S_RECORD)
        begin
            err_reg   <= tpfc_pkg::ERR_W'(temp_reg) - tpfc_pkg::ERR_W'(setpoint_reg);
            level_reg <= level_calc;
            buz_reg   <= (level_calc == tpfc_pkg::LEVEL_CRIT)
                         && (prev_level_reg != tpfc_pkg::LEVEL_CRIT);
            rec_reg   <= (temp_reg > max_reg) || (temp_reg < min_reg);
        end
        if (state_reg == S_MUL_I)
        begin
            prop_reg <= mul_reg;
        end
        if (state_reg == S_WINDUP)
        begin
            // Arithmetic shift gives the floor of integ_gain*err/256
            integ_sum_reg <= (mul_reg >>> 8)
                             + signed'(tpfc_pkg::PROD_W'(integ_reg));
        end
        if (state_reg == S_DUTY)
        begin
            duty_reg <= duty_calc;
        end
        if (out_load)
        begin
            out_temp_reg  <= temp_reg;
            out_duty_reg  <= duty_reg;
            out_level_reg <= level_reg;
            out_buz_reg   <= buz_reg;
            out_high_reg  <= max_reg;
            out_low_reg   <= min_reg[tpfc_pkg::LOWEST_W-1:0];
            out_rec_reg   <= rec_reg;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.temperature    = out_temp_reg;
    assign results.fan_duty       = out_duty_reg;
    assign results.alert_level    = out_level_reg;
    assign results.buzzer_start   = out_buz_reg;
    assign results.highest_seen   = out_high_reg;
    assign results.lowest_seen    = out_low_reg;
    assign results.record_changed = out_rec_reg;

endmodule

@@ src/tpfc_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module tpfc_divider #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DIVIDEND_W);
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= DIVISOR_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_reg <= trial[DIVISOR_W-1:0];
            end
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ dv/temperature_pi_fan_controller_test.sv @@
`timescale 1ns / 100ps

module temperature_pi_fan_controller_test;

    // --------------------------------------------------------------------
    // Run shape
    // --------------------------------------------------------------------
    localparam int AVG_DEPTH     = 5;
    localparam int SAMPLE_MAX    = (1 << tpfc_pkg::SAMPLE_W) - 1;
    localparam int CFG_INDEX_TOP = (1 << tpfc_pkg::CFG_INDEX_W) - 1;
    localparam int TEMP_LOW      = -12800;   // 0 code, -50 degC
    localparam int TEMP_HIGH     = 115200;   // 450 degC, top of register range
    localparam int N_CHUNKS      = 12;       // random part: 4 chunks per idle pattern
    localparam int CHUNK_ITEMS   = 153;
    localparam int SETTLE_CYCLES = 40;       // settle time after the last result has come back
    localparam int HOLD_CYCLES   = 300;      // long receiver hold-off
    localparam int RUN_LIMIT_NS  = 2000000;  // watchdog time limit, in ns

    typedef struct {
        logic signed [tpfc_pkg::TEMP_W-1:0]   temperature;
        logic [tpfc_pkg::DUTY_W-1:0]          fan_duty;
        logic [tpfc_pkg::LEVEL_W-1:0]         alert_level;
        logic                                 buzzer_start;
        logic signed [tpfc_pkg::TEMP_W-1:0]   highest_seen;
        logic signed [tpfc_pkg::LOWEST_W-1:0] lowest_seen;
        logic                                 record_changed;
    } fan_status_t;

    // --------------------------------------------------------------------
    // Scoreboard: predicts the status for every accepted sample and
    // matches results against the oldest pending prediction.
    // --------------------------------------------------------------------
    class fan_status_board_t;
        fan_status_t status_due[$];
        int          mismatches;

        // moving average window
        int          ring[AVG_DEPTH];
        int          ring_pos;
        int          fill;
        int          total;

        // controller state, all in plain signed math
        longint           integ;
        longint           hi_rec;
        longint           lo_rec;
        tpfc_pkg::level_t prev_level;

        // register copies
        longint      setpoint;
        longint      prop_gain;
        longint      integ_gain;
        longint      upper_limit;
        longint      lower_limit;

        function new();
            mismatches  = 0;
            ring_pos    = 0;
            fill        = 0;
            total       = 0;
            integ       = 0;
            hi_rec      = longint'(tpfc_pkg::MAX_RECORD_RST);
            lo_rec      = longint'(tpfc_pkg::MIN_RECORD_RST);
            prev_level  = tpfc_pkg::LEVEL_OK;
            setpoint    = longint'(tpfc_pkg::SETPOINT_RST);
            prop_gain   = longint'(tpfc_pkg::PROP_GAIN_RST);
            integ_gain  = longint'(tpfc_pkg::INTEG_GAIN_RST);
            upper_limit = longint'(tpfc_pkg::UPPER_LIMIT_RST);
            lower_limit = longint'(tpfc_pkg::LOWER_LIMIT_RST);
            foreach (ring[i])
                ring[i] = 0;
        endfunction

        function int pending();
            return status_due.size();
        endfunction

        function void note_write(logic [tpfc_pkg::CFG_INDEX_W-1:0] idx,
                                 logic [tpfc_pkg::CFG_DATA_W-1:0] data);
            unique case (idx)
                tpfc_pkg::REG_SETPOINT:
                begin
                    setpoint = longint'($signed(data));
                    integ    = 0;   // setpoint write restarts the integrator
                end
                tpfc_pkg::REG_PROP_GAIN:   prop_gain   = longint'(data[tpfc_pkg::GAIN_W-1:0]);
                tpfc_pkg::REG_INTEG_GAIN:  integ_gain  = longint'(data[tpfc_pkg::GAIN_W-1:0]);
                tpfc_pkg::REG_UPPER_LIMIT: upper_limit = longint'($signed(data));
                tpfc_pkg::REG_LOWER_LIMIT: lower_limit = longint'($signed(data));
                default: ;          // unused index, dropped
            endcase
        endfunction

        function void take_sample(logic [tpfc_pkg::SAMPLE_W-1:0] code);
            int               slot;
            longint           temp_now;
            longint           err;
            longint           pi_sum;
            longint           duty_acc;
            tpfc_pkg::level_t lvl;
            fan_status_t      st;

            slot = ring_pos;
            if (fill < AVG_DEPTH)
            begin
                fill++;
                total += int'(code);
            end
            else
            begin
                total = total - ring[slot] + int'(code);
            end
            ring[slot] = int'(code);
            ring_pos   = (slot + 1) % AVG_DEPTH;

            temp_now = (longint'(total) * longint'(tpfc_pkg::TEMP_STEP)) / longint'(fill)
                       - longint'(tpfc_pkg::TEMP_OFFSET);

            st.record_changed = 1'b0;
            if (temp_now > hi_rec)
            begin
                hi_rec            = temp_now;
                st.record_changed = 1'b1;
            end
            if (temp_now < lo_rec)
            begin
                lo_rec            = temp_now;
                st.record_changed = 1'b1;
            end

            // conditional integration: only while the unclamped output is inside 0..255
            err    = temp_now - setpoint;
            pi_sum = prop_gain * err + integ * 256;
            if (pi_sum > 0 && pi_sum < longint'(tpfc_pkg::DUTY_LIMIT))
            begin
                integ += (integ_gain * err) >>> 8;
                if (integ < 0)
                    integ = 0;
                if (integ > longint'(tpfc_pkg::INTEG_MAX))
                    integ = longint'(tpfc_pkg::INTEG_MAX);
            end

            duty_acc = prop_gain * err + integ * 256;
            if (duty_acc < 0)
                st.fan_duty = '0;
            else if (duty_acc >= longint'(tpfc_pkg::DUTY_LIMIT))
                st.fan_duty = tpfc_pkg::DUTY_MAX;
            else
                st.fan_duty = duty_acc[23:16];

            // critical beats cold when the limits cross
            if (temp_now >= upper_limit)
                lvl = tpfc_pkg::LEVEL_CRIT;
            else if (temp_now <= lower_limit)
                lvl = tpfc_pkg::LEVEL_COLD;
            else
                lvl = tpfc_pkg::LEVEL_OK;
            st.buzzer_start = (lvl == tpfc_pkg::LEVEL_CRIT
                               && prev_level != tpfc_pkg::LEVEL_CRIT);
            prev_level      = lvl;

            st.temperature  = temp_now[tpfc_pkg::TEMP_W-1:0];
            st.alert_level  = lvl;
            st.highest_seen = hi_rec[tpfc_pkg::TEMP_W-1:0];
            st.lowest_seen  = lo_rec[tpfc_pkg::LOWEST_W-1:0];
            status_due.push_back(st);
        endfunction

        task flag_mismatch(string what, longint got, longint want);
            $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
            mismatches++;
        endtask

        task compare_status(fan_status_t got);
            fan_status_t want;
            if (status_due.size() == 0)
            begin
                flag_mismatch("unexpected result, temperature",
                              longint'(got.temperature), longint'(0));
                return;
            end
            want = status_due.pop_front();
            if (got.temperature !== want.temperature)
                flag_mismatch("temperature", longint'(got.temperature),
                              longint'(want.temperature));
            if (got.fan_duty !== want.fan_duty)
                flag_mismatch("fan_duty", longint'(got.fan_duty), longint'(want.fan_duty));
            if (got.alert_level !== want.alert_level)
                flag_mismatch("alert_level", longint'(got.alert_level),
                              longint'(want.alert_level));
            if (got.buzzer_start !== want.buzzer_start)
                flag_mismatch("buzzer_start", longint'(got.buzzer_start),
                              longint'(want.buzzer_start));
            if (got.highest_seen !== want.highest_seen)
                flag_mismatch("highest_seen", longint'(got.highest_seen),
                              longint'(want.highest_seen));
            if (got.lowest_seen !== want.lowest_seen)
                flag_mismatch("lowest_seen", longint'(got.lowest_seen),
                              longint'(want.lowest_seen));
            if (got.record_changed !== want.record_changed)
                flag_mismatch("record_changed", longint'(got.record_changed),
                              longint'(want.record_changed));
        endtask
    endclass

    // --------------------------------------------------------------------
    // Clock, channels, DUT
    // --------------------------------------------------------------------
    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [tpfc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tpfc_pkg::CFG_DATA_W-1:0]  cfg_data;

    tpfc_sample_if sample_ch ();
    tpfc_result_if result_ch ();

    fan_status_board_t board;

    // idle odds in percent, changed only between chunks
    int send_idle_pct;
    int recv_idle_pct;
    // bumped by the stimulus; the receiver loads its hold-off counter on change
    int hold_requests;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    temperature_pi_fan_controller #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // --------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. Samples and
    // register writes feed the predictor, results are checked.
    // --------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        fan_status_t got;
        if (cfg_wr_en === 1'b1)
            board.note_write(cfg_index, cfg_data);
        if (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
            board.take_sample(sample_ch.adc_sample);
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got.temperature    = result_ch.temperature;
            got.fan_duty       = result_ch.fan_duty;
            got.alert_level    = result_ch.alert_level;
            got.buzzer_start   = result_ch.buzzer_start;
            got.highest_seen   = result_ch.highest_seen;
            got.lowest_seen    = result_ch.lowest_seen;
            got.record_changed = result_ch.record_changed;
            board.compare_status(got);
        end
    end

    // --------------------------------------------------------------------
    // Result side: random ready at the falling edge, plus long hold-offs
    // on request so the block backs up and stalls its sample input.
    // --------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left       = 0;
        hold_seen       = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // --------------------------------------------------------------------
    // Driver tasks, all entered and left at a falling edge
    // --------------------------------------------------------------------

    // One sample transfer. valid stays high on return so back-to-back
    // transfers need no extra step; whoever stops sending lowers it.
    task send_sample(input int code);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.adc_sample <= code[tpfc_pkg::SAMPLE_W-1:0];
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    // Stop offering, wait until every predicted status has come back,
    // then let the sequencer settle for the given number of cycles.
    task wait_results_done(input int settle);
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // Single-cycle register write; cfg_wr_en is lowered again before the task returns.
    task write_reg(input logic [tpfc_pkg::CFG_INDEX_W-1:0] idx,
                   input logic [tpfc_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Register settings for one random chunk; the block must be idle.
    task load_settings(input int kind);
        logic [tpfc_pkg::CFG_DATA_W-1:0] sp;
        logic [tpfc_pkg::CFG_DATA_W-1:0] up;
        logic [tpfc_pkg::CFG_DATA_W-1:0] lo;
        logic [tpfc_pkg::CFG_DATA_W-1:0] kp;
        logic [tpfc_pkg::CFG_DATA_W-1:0] ki;
        unique case (kind)
            0:
            begin   // power-on values
                sp = tpfc_pkg::CFG_DATA_W'(tpfc_pkg::SETPOINT_RST);
                kp = tpfc_pkg::CFG_DATA_W'(tpfc_pkg::PROP_GAIN_RST);
                ki = tpfc_pkg::CFG_DATA_W'(tpfc_pkg::INTEG_GAIN_RST);
                up = tpfc_pkg::CFG_DATA_W'(tpfc_pkg::UPPER_LIMIT_RST);
                lo = tpfc_pkg::CFG_DATA_W'(tpfc_pkg::LOWER_LIMIT_RST);
            end
            1:
            begin   // anything inside the documented ranges
                sp = tpfc_pkg::CFG_DATA_W'(int'($urandom_range(0, TEMP_HIGH - TEMP_LOW))
                                           + TEMP_LOW);
                kp = tpfc_pkg::CFG_DATA_W'($urandom_range(0, 65535));
                ki = tpfc_pkg::CFG_DATA_W'($urandom_range(0, 65535));
                up = tpfc_pkg::CFG_DATA_W'(int'($urandom_range(0, TEMP_HIGH - TEMP_LOW))
                                           + TEMP_LOW);
                lo = tpfc_pkg::CFG_DATA_W'(int'($urandom_range(0, TEMP_HIGH - TEMP_LOW))
                                           + TEMP_LOW);
            end
            2:
            begin   // range corners
                sp = tpfc_pkg::CFG_DATA_W'($urandom_range(0, 1) ? TEMP_HIGH : TEMP_LOW);
                kp = tpfc_pkg::CFG_DATA_W'($urandom_range(0, 1) ? 65535 : 0);
                ki = tpfc_pkg::CFG_DATA_W'($urandom_range(0, 1) ? 65535 : 0);
                up = tpfc_pkg::CFG_DATA_W'($urandom_range(0, 1) ? TEMP_HIGH : TEMP_LOW);
                lo = tpfc_pkg::CFG_DATA_W'($urandom_range(0, 1) ? TEMP_HIGH : TEMP_LOW);
            end
            3:
            begin   // raw 18 bit data, out-of-range and unused indices too
                sp = tpfc_pkg::CFG_DATA_W'($urandom);
                kp = tpfc_pkg::CFG_DATA_W'($urandom);
                ki = tpfc_pkg::CFG_DATA_W'($urandom);
                up = tpfc_pkg::CFG_DATA_W'($urandom);
                lo = tpfc_pkg::CFG_DATA_W'($urandom);
                for (int i = tpfc_pkg::REG_LOWER_LIMIT + 1; i <= CFG_INDEX_TOP; i++)
                    write_reg(i[tpfc_pkg::CFG_INDEX_W-1:0], tpfc_pkg::CFG_DATA_W'($urandom));
            end
            default:
            begin   // realistic loop: band around a room-ish setpoint
                sp = tpfc_pkg::CFG_DATA_W'($urandom_range(2560, 12800));
                kp = tpfc_pkg::CFG_DATA_W'($urandom_range(256, 8192));
                ki = tpfc_pkg::CFG_DATA_W'($urandom_range(0, 2048));
                up = sp + tpfc_pkg::CFG_DATA_W'($urandom_range(256, 1536));
                lo = sp - tpfc_pkg::CFG_DATA_W'($urandom_range(256, 1536));
            end
        endcase
        write_reg(tpfc_pkg::REG_PROP_GAIN, kp);
        write_reg(tpfc_pkg::REG_INTEG_GAIN, ki);
        write_reg(tpfc_pkg::REG_UPPER_LIMIT, up);
        write_reg(tpfc_pkg::REG_LOWER_LIMIT, lo);
        write_reg(tpfc_pkg::REG_SETPOINT, sp);
    endtask

    function automatic int clamp_code(int v);
        if (v < 0)
            return 0;
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        return v;
    endfunction

    // --------------------------------------------------------------------
    // Stimulus and end of run
    // --------------------------------------------------------------------
    initial
    begin : stimulus
        int fill_codes[];
        int cross_codes[];
        int windup_codes[];
        int odd_reg_codes[];
        int walk;
        int code;
        int roll;
        int pattern;

        board                = new();
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.adc_sample = '0;
        hold_requests        = 0;
        send_idle_pct        = 27;
        recv_idle_pct        = 48;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: window filling from reset, code extremes, ring wrap.
        fill_codes = '{0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0, 0};
        foreach (fill_codes[i])
            send_sample(fill_codes[i]);
        wait_results_done(SETTLE_CYCLES);

        // Crossed limits (critical must win), maximum gains, top setpoint.
        write_reg(tpfc_pkg::REG_SETPOINT, tpfc_pkg::CFG_DATA_W'(TEMP_HIGH));
        write_reg(tpfc_pkg::REG_PROP_GAIN, 18'h0FFFF);
        write_reg(tpfc_pkg::REG_INTEG_GAIN, 18'h0FFFF);
        write_reg(tpfc_pkg::REG_UPPER_LIMIT, tpfc_pkg::CFG_DATA_W'(TEMP_LOW));
        write_reg(tpfc_pkg::REG_LOWER_LIMIT, tpfc_pkg::CFG_DATA_W'(TEMP_HIGH));
        cross_codes = '{160, SAMPLE_MAX, 0, 512, 1};
        foreach (cross_codes[i])
            send_sample(cross_codes[i]);
        wait_results_done(SETTLE_CYCLES);

        // Integrator windup against its ceiling, then back down.
        write_reg(tpfc_pkg::REG_SETPOINT, tpfc_pkg::CFG_DATA_W'(TEMP_LOW));
        write_reg(tpfc_pkg::REG_PROP_GAIN, 18'd1);
        write_reg(tpfc_pkg::REG_INTEG_GAIN, 18'h0FFFF);
        write_reg(tpfc_pkg::REG_UPPER_LIMIT, tpfc_pkg::CFG_DATA_W'(TEMP_HIGH));
        write_reg(tpfc_pkg::REG_LOWER_LIMIT, tpfc_pkg::CFG_DATA_W'(TEMP_LOW));
        windup_codes = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0};
        foreach (windup_codes[i])
            send_sample(windup_codes[i]);
        wait_results_done(SETTLE_CYCLES);

        // Out-of-range register data and unused indices.
        write_reg(tpfc_pkg::REG_SETPOINT, 18'h1FFFF);
        write_reg(tpfc_pkg::REG_UPPER_LIMIT, 18'h20000);
        write_reg(tpfc_pkg::REG_LOWER_LIMIT, 18'h1FFFF);
        for (int i = tpfc_pkg::REG_LOWER_LIMIT + 1; i <= CFG_INDEX_TOP; i++)
            write_reg(i[tpfc_pkg::CFG_INDEX_W-1:0], 18'h3FFFF);
        odd_reg_codes = '{300, 700, 5};
        foreach (odd_reg_codes[i])
            send_sample(odd_reg_codes[i]);

        // Random part: a slow random walk around the setpoint so the loop
        // spends time in the linear band and alerts toggle, with jumps and
        // single-sample spikes as noise.
        for (int chunk = 0; chunk < N_CHUNKS; chunk++)
        begin
            wait_results_done(SETTLE_CYCLES);
            pattern = chunk / (N_CHUNKS / 3);
            unique case (pattern)
                0:
                begin
                    send_idle_pct = 27;
                    recv_idle_pct = 48;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 27;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            load_settings(chunk % 5);
            walk = clamp_code(int'((board.setpoint - TEMP_LOW) / 125)
                              + int'($urandom_range(0, 40)) - 20);

            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                if (n == CHUNK_ITEMS / 2)
                begin
                    // receiver backs off while samples keep coming
                    if (chunk == 1 || chunk == 9)
                        hold_requests <= hold_requests + 1;
                    // sender pauses until the pipe is empty
                    if (chunk == 2 || chunk == 10)
                        wait_results_done(0);
                end
                roll = int'($urandom_range(0, 99));
                if (roll < 78)
                begin
                    walk = clamp_code(walk + int'($urandom_range(0, 12)) - 6);
                    code = walk;
                end
                else if (roll < 88)
                begin
                    walk = int'($urandom_range(0, SAMPLE_MAX));
                    code = walk;
                end
                else if (roll < 94)
                begin
                    code = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
                end
                else
                begin
                    code = int'($urandom_range(0, SAMPLE_MAX));
                end
                send_sample(code);
            end
        end

        wait_results_done(SETTLE_CYCLES);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: a stuck handshake ends the run here.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ temperature_pi_fan_controller.f @@
src/tpfc_pkg.sv
src/tpfc_sample_if.sv
src/tpfc_result_if.sv
src/tpfc_divider.sv
src/temperature_pi_fan_controller.sv
dv/temperature_pi_fan_controller_test.sv
